/* hw/rtl/mmr_pkg.sv */
// ============================================================================
// mmr_pkg
// Shared types, codes and constants of the message mailbox ring.
// ============================================================================
package mmr_pkg;

    // Default sizing of the block
    localparam int DEF_STORE_DEPTH = 256;
    localparam int DEF_MAX_MSG_LEN = 64;

    // Smallest ring the size register can select
    localparam int MIN_RING = 8;

    // Bytes of the little-endian length header at the head of a message
    localparam int HDR_BYTES = 4;

    // Register reset values
    localparam logic [8:0] SIZE_RESET    = 9'd256;
    localparam logic [6:0] MIN_LEN_RESET = 7'd4;

    // Operation codes of an input word
    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SIZE    = 2'd0,
        CFG_MIN_LEN = 2'd1,
        CFG_CREATED = 2'd2
    } t_cfg_idx;

    // Result status codes
    typedef enum logic [2:0] {
        RS_DATA       = 3'd0,
        RS_SEND_OK    = 3'd1,
        RS_SEND_REJ   = 3'd2,
        RS_RECV_DISC  = 3'd3,
        RS_RECV_EMPTY = 3'd4
    } t_status;

    // Input word
    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic [6:0] message_length;
        logic       final_byte;
        logic [7:0] sender_in;
        logic [6:0] receive_capacity;
        logic       buffer_absent;
    } t_in_item;

    // Output word
    typedef struct packed {
        logic [7:0] byte_out;
        logic [7:0] sender_out;
        t_status    status;
        logic       last_item;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SNDR,
        S_HDR,
        S_EVAL,
        S_DEC,
        S_SWAIT,
        S_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_send;
        logic take_recv;
        logic commit;
        logic hdr_step;
        logic eval;
        logic decide;
        logic grab;
        logic emit;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic send_commit;
        logic recv_empty;
        logic hdr_done;
        logic discard;
        logic last_byte;
    } t_stat;

endpackage

/* hw/rtl/mmr_ctrl.sv */
// ============================================================================
// mmr_ctrl
// Sequencer of the mailbox: accepts words, steps the header read, the
// receive decision and the byte stream of a delivered message.
// ============================================================================
module mmr_ctrl import mmr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_op,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.out_free) begin
                    if (i_op == OP_SEND) begin
                        if (i_stat.send_commit) begin
                            n_state = S_SNDR;
                        end
                    end else if (!i_stat.recv_empty) begin
                        n_state = S_HDR;
                    end
                end
            end
            S_SNDR:  n_state = S_IDLE;
            S_HDR: begin
                if (i_stat.hdr_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL:  n_state = S_DEC;
            S_DEC:   n_state = i_stat.discard ? S_IDLE : S_SWAIT;
            S_SWAIT: n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free && i_stat.last_byte) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready        = i_stat.out_free;
                o_cmd.take_send   = i_stat.out_free && i_in_valid && (i_op == OP_SEND);
                o_cmd.take_recv   = i_stat.out_free && i_in_valid && (i_op == OP_RECV);
            end
            S_SNDR:  o_cmd.commit   = 1'b1;
            S_HDR:   o_cmd.hdr_step = 1'b1;
            S_EVAL:  o_cmd.eval     = 1'b1;
            S_DEC:   o_cmd.decide   = 1'b1;
            S_SWAIT: o_cmd.grab     = 1'b1;
            S_OUT:   o_cmd.emit     = i_stat.out_free;
            default: o_cmd          = '0;
        endcase
    end

endmodule

/* hw/rtl/mmr_dp.sv */
// ============================================================================
// mmr_dp
// Datapath of the mailbox: byte store, ring pointers, used count, send
// tracking, header assembly and the output word register.
// ============================================================================
module mmr_dp import mmr_pkg::*; #(
    parameter int STORE_DEPTH     = DEF_STORE_DEPTH,
    parameter int MAX_MESSAGE_LEN = DEF_MAX_MSG_LEN
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [$clog2(STORE_DEPTH+1)-1:0]   i_ring_size,
    input  logic [6:0]                         i_min_len,
    input  logic                               i_created,
    input  logic                               i_clear,
    input  t_in_item                           i_in_data,
    input  logic                               i_out_ready,
    input  t_cmd                               i_cmd,
    output t_stat                              o_stat,
    output logic                               o_out_valid,
    output t_out_item                          o_out_data
);

    localparam int PTR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int OFF_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int IDX_W = $clog2(MAX_MESSAGE_LEN + 1);
    localparam int CHK_W = ((CNT_W > 7) ? CNT_W : 7) + 1;
    localparam logic [6:0]       MAX_LEN = 7'(MAX_MESSAGE_LEN);
    localparam logic [IDX_W-1:0] HDR_END = IDX_W'(HDR_BYTES);

    // Ring position base + off, with base + off below twice the ring size
    function automatic logic [PTR_W-1:0] slot(
        input logic [PTR_W-1:0] base,
        input logic [OFF_W-1:0] off,
        input logic [CNT_W-1:0] size
    );
        logic [OFF_W:0] sum;
        sum = (OFF_W+1)'(base) + (OFF_W+1)'(off);
        if (sum >= (OFF_W+1)'(size)) begin
            sum = sum - (OFF_W+1)'(size);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Byte store
    logic [7:0] mem [STORE_DEPTH];

    // Control state
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W-1:0] r_wp;
    logic [CNT_W-1:0] r_used;
    logic             r_send_active;
    logic             r_send_rej;
    logic [6:0]       r_len;
    logic [7:0]       r_cnt;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;

    // Payload state
    logic [7:0]       r_snd_id;
    logic [6:0]       r_cap;
    logic             r_absent;
    logic [31:0]      r_hdr;
    logic [CNT_W-1:0] r_msg;
    logic [7:0]       r_rcv_id;
    logic [7:0]       r_rd_data;
    t_out_item        r_out;

    // Send evaluation
    logic             first;
    logic [CHK_W-1:0] len_p1;
    logic [CNT_W-1:0] free_bytes;
    logic             bad;
    logic [6:0]       eff_len;
    logic             eff_rej;
    logic [7:0]       eff_cnt;
    logic [7:0]       cnt_inc;
    logic             send_ok;
    logic             store_byte;

    // Receive evaluation
    logic [CNT_W-1:0] used_m1;
    logic [6:0]       cap_eff;
    logic [CNT_W-1:0] msg_clip;
    logic             discard;
    logic [OFF_W-1:0] msg_p1;
    logic             last_byte;
    logic [PTR_W-1:0] rp_adv;
    logic             out_free;

    // Memory ports
    logic             rd_en;
    logic [OFF_W-1:0] rd_off;
    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [7:0]       wr_data;

    // Output load
    logic             out_load;
    t_out_item        out_next;

    // Check a send on its first byte, then track its byte count
    always_comb begin
        first      = !r_send_active;
        len_p1     = CHK_W'(i_in_data.message_length) + CHK_W'(1);
        free_bytes = i_ring_size - r_used;
        bad        = !i_created
                   || (len_p1 > CHK_W'(i_ring_size))
                   || (len_p1 > CHK_W'(free_bytes))
                   || (i_in_data.message_length < i_min_len)
                   || (i_in_data.message_length > MAX_LEN);
        eff_len    = first ? i_in_data.message_length : r_len;
        eff_rej    = first ? bad : r_send_rej;
        eff_cnt    = first ? 8'd0 : r_cnt;
        cnt_inc    = (eff_cnt != 8'hFF) ? eff_cnt + 8'd1 : eff_cnt;
        send_ok    = !eff_rej && (cnt_inc == {1'b0, eff_len});
        store_byte = !eff_rej && (eff_cnt < {1'b0, eff_len});
    end

    // Clip the stored length and decide delivery or discard
    always_comb begin
        used_m1   = r_used - CNT_W'(1);
        cap_eff   = (i_in_data.receive_capacity > MAX_LEN) ? MAX_LEN
                                                           : i_in_data.receive_capacity;
        msg_clip  = (r_hdr > 32'(used_m1)) ? used_m1 : r_hdr[CNT_W-1:0];
        discard   = r_absent || (r_msg == '0) || (OFF_W'(r_msg) > OFF_W'(r_cap));
        msg_p1    = OFF_W'(r_msg) + OFF_W'(1);
        last_byte = (OFF_W'(r_idx) + OFF_W'(1)) == OFF_W'(r_msg);
        rp_adv    = slot(r_rp, msg_p1, i_ring_size);
        out_free  = !r_out_valid || i_out_ready;
    end

    // Select the read offset
    always_comb begin
        rd_en  = 1'b0;
        rd_off = '0;
        if (i_cmd.hdr_step) begin
            rd_en  = (r_idx != HDR_END);
            rd_off = OFF_W'(r_idx);
        end else if (i_cmd.decide) begin
            rd_en  = !discard;
            rd_off = OFF_W'(r_msg);
        end else if (i_cmd.grab) begin
            rd_en  = 1'b1;
            rd_off = '0;
        end else if (i_cmd.emit) begin
            rd_en  = !last_byte;
            rd_off = OFF_W'(r_idx) + OFF_W'(1);
        end
        rd_addr = slot(r_rp, rd_off, i_ring_size);
    end

    // Select the write: sender byte on commit, message byte on a send word
    always_comb begin
        if (i_cmd.commit) begin
            wr_en   = 1'b1;
            wr_addr = slot(r_wp, OFF_W'(r_len), i_ring_size);
            wr_data = r_snd_id;
        end else begin
            wr_en   = i_cmd.take_send && store_byte;
            wr_addr = slot(r_wp, OFF_W'(eff_cnt), i_ring_size);
            wr_data = i_in_data.data_byte;
        end
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Pick the next output word
    always_comb begin
        out_load = 1'b0;
        out_next = '{byte_out: 8'd0, sender_out: 8'd0, status: RS_DATA, last_item: 1'b1};
        if (i_cmd.take_send && i_in_data.final_byte && !send_ok) begin
            out_load        = 1'b1;
            out_next.status = RS_SEND_REJ;
        end else if (i_cmd.take_recv && (!i_created || (r_used == '0))) begin
            out_load        = 1'b1;
            out_next.status = RS_RECV_EMPTY;
        end else if (i_cmd.commit) begin
            out_load        = 1'b1;
            out_next.status = RS_SEND_OK;
        end else if (i_cmd.decide && discard) begin
            out_load        = 1'b1;
            out_next.status = RS_RECV_DISC;
        end else if (i_cmd.emit) begin
            out_load            = 1'b1;
            out_next.byte_out   = r_rd_data;
            out_next.sender_out = r_rcv_id;
            out_next.status     = RS_DATA;
            out_next.last_item  = last_byte;
        end
    end

    // Pointers, counts and send tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp          <= '0;
            r_wp          <= '0;
            r_used        <= '0;
            r_send_active <= 1'b0;
            r_send_rej    <= 1'b0;
            r_len         <= '0;
            r_cnt         <= '0;
            r_idx         <= '0;
        end else if (i_clear) begin
            r_rp          <= '0;
            r_wp          <= '0;
            r_used        <= '0;
            r_send_active <= 1'b0;
            r_send_rej    <= 1'b0;
            r_len         <= '0;
            r_cnt         <= '0;
        end else begin
            if (i_cmd.take_send) begin
                r_len <= eff_len;
                r_cnt <= cnt_inc;
                if (i_in_data.final_byte) begin
                    r_send_active <= 1'b0;
                    r_send_rej    <= 1'b0;
                end else begin
                    r_send_active <= 1'b1;
                    r_send_rej    <= eff_rej;
                end
            end
            if (i_cmd.commit) begin
                r_wp   <= slot(r_wp, OFF_W'(r_len) + OFF_W'(1), i_ring_size);
                r_used <= r_used + CNT_W'(r_len) + CNT_W'(1);
            end
            if ((i_cmd.decide && discard) || (i_cmd.emit && last_byte)) begin
                r_rp   <= rp_adv;
                r_used <= r_used - r_msg - CNT_W'(1);
            end
            if (i_cmd.take_recv || i_cmd.decide) begin
                r_idx <= '0;
            end else if (i_cmd.hdr_step || (i_cmd.emit && !last_byte)) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // Capture request fields, header bytes, clipped length, sender and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_send && i_in_data.final_byte) begin
            r_snd_id <= i_in_data.sender_in;
        end
        if (i_cmd.take_recv) begin
            r_cap    <= cap_eff;
            r_absent <= i_in_data.buffer_absent;
        end
        if (i_cmd.hdr_step && (r_idx != '0)) begin
            r_hdr <= {r_rd_data, r_hdr[31:8]};
        end
        if (i_cmd.eval) begin
            r_msg <= msg_clip;
        end
        if (i_cmd.grab) begin
            r_rcv_id <= r_rd_data;
        end
        if (out_load) begin
            r_out <= out_next;
        end
    end

    // Output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free    = out_free;
    assign o_stat.send_commit = i_in_data.final_byte && send_ok;
    assign o_stat.recv_empty  = !i_created || (r_used == '0);
    assign o_stat.hdr_done    = (r_idx == HDR_END);
    assign o_stat.discard     = discard;
    assign o_stat.last_byte   = last_byte;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

endmodule

/* hw/rtl/message_mailbox_ring.sv */
// ============================================================================
// message_mailbox_ring
// Byte-wide circular mailbox of variable-length messages, each stored with
// a trailing sender id byte; one word at a time through a dual-port store.
//
// A send byte that is not the last of its message is taken in the idle state;
// the last byte of an accepted send is followed by a commit state, in which the
// sender id is written to the store; a rejected send answers from the idle
// state, as does a receive on an empty or absent mailbox. Otherwise the four
// length header bytes are read through the store's one read port, the length
// is clipped and then judged, and a discard then answers; a delivered message
// takes a state to fetch the sender and streams its bytes at one per cycle
// while the output is ready. A write to mailbox_size or mailbox_created
// empties the mailbox and drops a send in progress. The store needs no
// clearing after reset.
// ============================================================================
module message_mailbox_ring import mmr_pkg::*; #(
    parameter int STORE_DEPTH     = DEF_STORE_DEPTH,
    parameter int MAX_MESSAGE_LEN = DEF_MAX_MSG_LEN
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int SZ_W  = (CNT_W > 9) ? CNT_W : 9;

    // Hold the size register to the range the store supports
    function automatic logic [CNT_W-1:0] ring_clamp(input logic [8:0] v);
        logic [SZ_W-1:0] ext;
        ext = SZ_W'(v);
        if (ext < SZ_W'(MIN_RING)) begin
            ext = SZ_W'(MIN_RING);
        end else if (ext > SZ_W'(STORE_DEPTH)) begin
            ext = SZ_W'(STORE_DEPTH);
        end
        return ext[CNT_W-1:0];
    endfunction

    logic [CNT_W-1:0] r_ring_size;
    logic [6:0]       r_min_len;
    logic             r_created;
    logic             cfg_write;
    logic             cfg_clear;
    t_cmd             cmd;
    t_stat            stat;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= ring_clamp(SIZE_RESET);
            r_min_len   <= MIN_LEN_RESET;
            r_created   <= 1'b0;
        end else if (cfg_write) begin
            case (i_cfg_index)
                CFG_SIZE:    r_ring_size <= ring_clamp(i_cfg_data);
                CFG_MIN_LEN: r_min_len   <= i_cfg_data[6:0];
                CFG_CREATED: r_created   <= i_cfg_data[0];
                default:     r_created   <= r_created;
            endcase
        end
    end

    // Empty the mailbox on every write to its size or existence register
    assign cfg_clear = cfg_write
                     && ((i_cfg_index == CFG_SIZE) || (i_cfg_index == CFG_CREATED));

    mmr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.operation),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    mmr_dp #(
        .STORE_DEPTH     (STORE_DEPTH),
        .MAX_MESSAGE_LEN (MAX_MESSAGE_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ring_size (r_ring_size),
        .i_min_len   (r_min_len),
        .i_created   (r_created),
        .i_clear     (cfg_clear),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
